// ===== design/omfdf_pkg.sv =====
// Shared constants for the OMF record deframer.
package omfdf_pkg;

  // Width of the running byte offset within a buffer (wraps at this width).
  localparam int OFFSET_BITS = 32;
  // Width of the reported record offset.
  localparam int REC_OFFSET_BITS = 32;
  // Internal width that holds both of the above.
  localparam int OFFSET_EXT_BITS =
    (OFFSET_BITS > REC_OFFSET_BITS) ? OFFSET_BITS : REC_OFFSET_BITS;

  // Type mask registers.
  localparam int MASK_BITS    = 64;
  localparam int MASK_REGS    = 4;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MASK_LOW   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MASK_MID   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MASK_UPPER = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MASK_TOP   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_BAD_SUM  = 2'd2;
  localparam logic [1:0] ST_SHORT    = 2'd3;

endpackage

// ===== design/omfdf_in_if.sv =====
// Byte stream channel into the deframer.
interface omfdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

// ===== design/omfdf_out_if.sv =====
// Record report channel out of the deframer.
interface omfdf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  record_type;
  logic [15:0] record_length;
  logic [omfdf_pkg::REC_OFFSET_BITS-1:0] record_offset;

  modport source (output valid, output status, output record_type,
                  output record_length, output record_offset, input ready);
  modport sink   (input valid, input status, input record_type,
                  input record_length, input record_offset, output ready);
endinterface

// ===== design/omf_record_deframer_unit.sv =====
// Top level of the OMF record deframer.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+------------------------------------------
//   bytes     | in  | valid/ready   | data_byte[7:0], buffer_end
//   records   | out | valid/ready   | status[1:0], record_type[7:0],
//             |     |               | record_length[15:0], record_offset[31:0]
//   cfg       | in  | cfg_we        | cfg_index[1:0], cfg_data[63:0]
//
// One byte per cycle sustained while records is not stalled. A byte is held in
// the input register, then one pass through the framing logic loads the result
// register, which drives the report on records.
// rst is synchronous: framing restarts expecting a type byte at offset zero,
// and the type mask clears, so every type is rejected until written.
// Stalls on records back up into the input register and then drop bytes.ready;
// while records is empty, bytes.ready is always high.
module omf_record_deframer_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [omfdf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [omfdf_pkg::MASK_BITS-1:0]     cfg_data,
  omfdf_in_if.sink                            bytes,
  omfdf_out_if.source                         records
);

  logic [7:0] lookup_type;
  logic       type_ok;

  // Mask lookup is combinational off the parser's input register.
  omfdf_type_mask u_type_mask (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .lookup_type (lookup_type),
    .type_ok     (type_ok)
  );

  omfdf_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .bytes       (bytes),
    .records     (records),
    .lookup_type (lookup_type),
    .type_ok     (type_ok)
  );

  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !records.valid |-> bytes.ready)
    else $error("bytes stalled with empty result register");

  // A checksum verdict only comes from a record with a nonzero length.
  a_sum_has_length: assert property (@(posedge clk) disable iff (rst)
    records.valid && (records.status == omfdf_pkg::ST_OK ||
                      records.status == omfdf_pkg::ST_BAD_SUM)
    |-> records.record_length != 16'd0)
    else $error("checksum verdict on zero-length record");

  // Bad type is decided on the type byte, before any length byte.
  a_bad_type_no_length: assert property (@(posedge clk) disable iff (rst)
    records.valid && records.status == omfdf_pkg::ST_BAD_TYPE
    |-> records.record_length == 16'd0)
    else $error("bad type report carries a length");

  // Nothing is reported in the cycle after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !records.valid)
    else $error("report right after reset");

endmodule

// ===== design/omfdf_type_mask.sv =====
// 256-bit accepted-type mask: four config registers and a per-type lookup.
module omfdf_type_mask (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [omfdf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [omfdf_pkg::MASK_BITS-1:0]     cfg_data,
  input  logic [7:0]                          lookup_type,
  output logic                                type_ok
);

  logic [omfdf_pkg::MASK_BITS-1:0] mask [omfdf_pkg::MASK_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < omfdf_pkg::MASK_REGS; i++) begin
        mask[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        omfdf_pkg::REG_MASK_LOW:   mask[0] <= cfg_data;
        omfdf_pkg::REG_MASK_MID:   mask[1] <= cfg_data;
        omfdf_pkg::REG_MASK_UPPER: mask[2] <= cfg_data;
        omfdf_pkg::REG_MASK_TOP:   mask[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Upper two bits pick the register, lower six the bit.
  assign type_ok = mask[lookup_type[7:6]][lookup_type[5:0]];

endmodule

// ===== design/omfdf_parser.sv =====
// Input register, record framing state machine and result register.
module omfdf_parser (
  input  logic                 clk,
  input  logic                 rst,
  omfdf_in_if.sink             bytes,
  omfdf_out_if.source          records,
  output logic [7:0]           lookup_type,
  input  logic                 type_ok
);

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY,
    PH_DISCARD
  } phase_t;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Framing state
  phase_t                              phase, phase_next;
  logic [7:0]                          held_type, held_type_next;
  logic [15:0]                         held_length, held_length_next;
  logic [15:0]                         bytes_left, bytes_left_next;
  logic [7:0]                          running_sum, running_sum_next;
  logic [omfdf_pkg::OFFSET_BITS-1:0]   byte_position, byte_position_next;
  logic [omfdf_pkg::OFFSET_BITS-1:0]   record_start, record_start_next;

  // Result register
  logic                                   out_valid;
  logic [1:0]                             out_status;
  logic [7:0]                             out_type;
  logic [15:0]                            out_length;
  logic [omfdf_pkg::REC_OFFSET_BITS-1:0]  out_offset;

  logic                                   emit;
  logic [1:0]                             emit_status;
  logic                                   advance;
  logic [omfdf_pkg::OFFSET_EXT_BITS-1:0]  start_ext;

  // Item leaves the input register when the result register has room.
  assign advance     = in_valid && (!out_valid || records.ready);
  assign bytes.ready = !in_valid || advance;
  assign lookup_type = in_byte;

  always_comb begin
    phase_next         = phase;
    held_type_next     = held_type;
    held_length_next   = held_length;
    bytes_left_next    = bytes_left;
    running_sum_next   = running_sum;
    record_start_next  = record_start;
    emit               = 1'b0;
    emit_status        = omfdf_pkg::ST_OK;

    case (phase)
      PH_TYPE: begin
        record_start_next = byte_position;
        held_type_next    = in_byte;
        held_length_next  = '0;
        running_sum_next  = in_byte;
        if (!type_ok) begin
          emit        = 1'b1;
          emit_status = omfdf_pkg::ST_BAD_TYPE;
          phase_next  = PH_DISCARD;
        end else if (in_last) begin
          emit        = 1'b1;
          emit_status = omfdf_pkg::ST_SHORT;
        end else begin
          phase_next  = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        held_length_next = {8'h00, in_byte};
        running_sum_next = running_sum + in_byte;
        if (in_last) begin
          emit        = 1'b1;
          emit_status = omfdf_pkg::ST_SHORT;
        end else begin
          phase_next  = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        held_length_next = {in_byte, held_length[7:0]};
        running_sum_next = running_sum + in_byte;
        bytes_left_next  = held_length_next;
        if (held_length_next == 16'd0 || in_last) begin
          emit        = 1'b1;
          emit_status = omfdf_pkg::ST_SHORT;
          phase_next  = PH_DISCARD;
        end else begin
          phase_next  = PH_BODY;
        end
      end
      PH_BODY: begin
        running_sum_next = running_sum + in_byte;
        bytes_left_next  = bytes_left - 16'd1;
        if (bytes_left_next == 16'd0) begin
          emit = 1'b1;
          // zero checksum byte means "not computed"
          if (in_byte == 8'h00 || running_sum_next == 8'h00) begin
            emit_status = omfdf_pkg::ST_OK;
            phase_next  = PH_TYPE;
          end else begin
            emit_status = omfdf_pkg::ST_BAD_SUM;
            phase_next  = PH_DISCARD;
          end
        end else if (in_last) begin
          emit        = 1'b1;
          emit_status = omfdf_pkg::ST_SHORT;
          phase_next  = PH_DISCARD;
        end
      end
      default: ;
    endcase

    if (in_last) begin
      phase_next         = PH_TYPE;
      byte_position_next = '0;
    end else begin
      byte_position_next = byte_position + 1'b1;
    end
  end

  assign start_ext = omfdf_pkg::OFFSET_EXT_BITS'(record_start_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      phase         <= PH_TYPE;
      held_type     <= '0;
      held_length   <= '0;
      bytes_left    <= '0;
      running_sum   <= '0;
      byte_position <= '0;
      record_start  <= '0;
    end else begin
      if (bytes.ready) begin
        in_valid <= bytes.valid;
      end
      if (advance) begin
        phase         <= phase_next;
        held_type     <= held_type_next;
        held_length   <= held_length_next;
        bytes_left    <= bytes_left_next;
        running_sum   <= running_sum_next;
        byte_position <= byte_position_next;
        record_start  <= record_start_next;
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (records.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (bytes.valid && bytes.ready) begin
      in_byte <= bytes.data_byte;
      in_last <= bytes.buffer_end;
    end
    if (advance && emit) begin
      out_status <= emit_status;
      out_type   <= held_type_next;
      out_length <= held_length_next;
      out_offset <= start_ext[omfdf_pkg::REC_OFFSET_BITS-1:0];
    end
  end

  assign records.valid         = out_valid;
  assign records.status        = out_status;
  assign records.record_type   = out_type;
  assign records.record_length = out_length;
  assign records.record_offset = out_offset;

endmodule
